@@ src/joystick_axis_offset_average_top_assert.svh @@
// Assertion macros shared by the checker.
`ifndef JOYSTICK_AXIS_OFFSET_AVERAGE_TOP_ASSERT_SVH
`define JOYSTICK_AXIS_OFFSET_AVERAGE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define JAOA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jaoa assertion failed");

// Next-cycle implication, disabled during reset.
`define JAOA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jaoa assertion failed");

`endif

@@ src/jaoa_pkg.sv @@
package jaoa_pkg;

  // Window is a power of two so the divide is a shift.
  localparam int DIV_SHIFT = 3;
  localparam int WINDOW    = 1 << DIV_SHIFT;

  localparam int AXIS_W   = 16;
  localparam int SUM_W    = AXIS_W + DIV_SHIFT;
  localparam int STATUS_W = 8;
  localparam int COUNT_W  = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_ALL_ONES = 8'hFF;
  localparam logic [STATUS_W-1:0] STATUS_ZERO     = 8'h00;
  localparam logic [STATUS_W-1:0] STATUS_ERR_MASK = 8'h10;

  typedef struct packed {
    logic signed [AXIS_W-1:0] x_smoothed;
    logic signed [AXIS_W-1:0] y_smoothed;
    logic                     status_bad;
    logic [COUNT_W-1:0]       bad_status_total;
  } result_t;

endpackage

@@ src/jaoa_axis_lane.sv @@
module jaoa_axis_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic signed [jaoa_pkg::AXIS_W-1:0]  raw,
  input  logic signed [jaoa_pkg::AXIS_W-1:0]  offset,
  output logic signed [jaoa_pkg::AXIS_W-1:0]  smoothed
);
  import jaoa_pkg::*;

  logic signed [AXIS_W-1:0] hist_r [WINDOW];
  logic [DIV_SHIFT-1:0]     slot_r;
  logic signed [SUM_W-1:0]  sum_r;

  logic signed [AXIS_W-1:0] corr;
  logic signed [AXIS_W-1:0] oldest;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [SUM_W-1:0]  biased;

  always_comb begin
    corr    = raw - offset;   // wraps to 16 bits
    oldest  = hist_r[slot_r];
    sum_nxt = sum_r - {{DIV_SHIFT{oldest[AXIS_W-1]}}, oldest}
                    + {{DIV_SHIFT{corr[AXIS_W-1]}}, corr};
    // bias negatives so the arithmetic shift truncates toward zero
    biased   = sum_nxt + (sum_nxt[SUM_W-1] ? SUM_W'(WINDOW - 1) : '0);
    smoothed = biased[SUM_W-1:DIV_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        hist_r[i] <= '0;
      end
      slot_r <= '0;
      sum_r  <= '0;
    end else if (step) begin
      hist_r[slot_r] <= corr;
      slot_r         <= slot_r + DIV_SHIFT'(1);
      sum_r          <= sum_nxt;
    end
  end

endmodule

@@ src/jaoa_status_count.sv @@
module jaoa_status_count (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic [jaoa_pkg::STATUS_W-1:0]       status_byte,
  output logic                                status_bad,
  output logic [jaoa_pkg::COUNT_W-1:0]        total
);
  import jaoa_pkg::*;

  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;

  always_comb begin
    status_bad = (status_byte == STATUS_ALL_ONES) || (status_byte == STATUS_ZERO) ||
                 ((status_byte & STATUS_ERR_MASK) != STATUS_ZERO);
    count_nxt  = count_r;
    if (status_bad && (count_r != '1)) begin
      count_nxt = count_r + COUNT_W'(1);
    end
    total = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (step) begin
      count_r <= count_nxt;
    end
  end

endmodule

@@ src/jaoa_merge.sv @@
module jaoa_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  jaoa_pkg::result_t    push_data,
  output logic                 space,
  output logic                 out_valid,
  input  logic                 out_ready,
  output jaoa_pkg::result_t    out_data
);
  import jaoa_pkg::*;

  // Output register plus one skid entry.
  result_t head_r;
  result_t spare_r;
  logic    head_valid_r;
  logic    spare_valid_r;
  logic    pop;

  assign space     = !spare_valid_r;
  assign out_valid = head_valid_r;
  assign out_data  = head_r;
  assign pop       = head_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r  <= 1'b0;
      spare_valid_r <= 1'b0;
    end else if (pop) begin
      if (spare_valid_r) begin
        head_valid_r  <= 1'b1;
        spare_valid_r <= 1'b0;
      end else begin
        head_valid_r <= push;
      end
    end else if (!head_valid_r) begin
      head_valid_r <= push;
    end else if (push) begin
      spare_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      head_r <= spare_valid_r ? spare_r : push_data;
    end else if (!head_valid_r) begin
      head_r <= push_data;
    end else if (push) begin
      spare_r <= push_data;
    end
  end

endmodule

@@ src/joystick_axis_offset_average_top.sv @@
// Joystick axis offset removal and 8-sample boxcar smoothing.
// Input channel (in_valid/in_ready): status byte plus signed X and Y readings.
// Result channel (out_valid/out_ready): smoothed X and Y, status_bad flag and
// the saturating bad-status count including the current item.
// Config port: cfg_we writes cfg_wdata to the X (index 0) or Y (index 1)
// zero offset; write only while no item is in flight.
// Throughput: one item per cycle while in_ready is high; X and Y lanes each
// update a running sum and an 8-entry ring in the accepting cycle, alongside
// the status counter; the item's result is registered into the result buffer.
// The result buffer holds two items, so in_ready stays high while one result
// waits; with out_ready held low, in_ready drops once both entries are full
// and rises again as soon as the receiver takes one.
// Reset clears offsets, rings, sums, the bad-status count and the buffer;
// the first seven averages include the zeros left in the rings.
module joystick_axis_offset_average_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [jaoa_pkg::STATUS_W-1:0]       in_status_byte,
  input  logic signed [jaoa_pkg::AXIS_W-1:0]  in_x_raw,
  input  logic signed [jaoa_pkg::AXIS_W-1:0]  in_y_raw,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [jaoa_pkg::AXIS_W-1:0]  out_x_smoothed,
  output logic signed [jaoa_pkg::AXIS_W-1:0]  out_y_smoothed,
  output logic                                out_status_bad,
  output logic [jaoa_pkg::COUNT_W-1:0]        out_bad_status_total,
  input  logic                                cfg_we,
  input  logic [jaoa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jaoa_pkg::AXIS_W-1:0]         cfg_wdata
);
  import jaoa_pkg::*;

  logic signed [AXIS_W-1:0] x_rest_r;
  logic signed [AXIS_W-1:0] y_rest_r;
  logic                     step;
  result_t                  res;
  result_t                  out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_rest_r <= '0;
      y_rest_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_OFFSET: x_rest_r <= cfg_wdata;
        CFG_Y_OFFSET: y_rest_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign step = in_valid && in_ready;

  jaoa_axis_lane u_x_lane (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .raw      (in_x_raw),
    .offset   (x_rest_r),
    .smoothed (res.x_smoothed)
  );

  jaoa_axis_lane u_y_lane (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .raw      (in_y_raw),
    .offset   (y_rest_r),
    .smoothed (res.y_smoothed)
  );

  jaoa_status_count u_status (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .status_byte (in_status_byte),
    .status_bad  (res.status_bad),
    .total       (res.bad_status_total)
  );

  jaoa_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .push_data (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_x_smoothed       = out_res.x_smoothed;
  assign out_y_smoothed       = out_res.y_smoothed;
  assign out_status_bad       = out_res.status_bad;
  assign out_bad_status_total = out_res.bad_status_total;

endmodule

@@ src/jaoa_checker.sv @@
`include "joystick_axis_offset_average_top_assert.svh"

module jaoa_port_props (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_ready,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [jaoa_pkg::AXIS_W-1:0]  out_x_smoothed,
  input  logic signed [jaoa_pkg::AXIS_W-1:0]  out_y_smoothed,
  input  logic                                out_status_bad,
  input  logic [jaoa_pkg::COUNT_W-1:0]        out_bad_status_total
);
  import jaoa_pkg::*;

  // Count carried by the last delivered item.
  logic [COUNT_W-1:0] last_total_r;
  logic [COUNT_W-1:0] bumped_total;
  logic               out_take;

  assign out_take     = out_valid && out_ready;
  assign bumped_total = (last_total_r == '1) ? last_total_r : last_total_r + COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_total_r <= '0;
    end else if (out_take) begin
      last_total_r <= out_bad_status_total;
    end
  end

  `JAOA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_x_smoothed) && $stable(out_y_smoothed)
                    && $stable(out_status_bad) && $stable(out_bad_status_total))
  `JAOA_ASSERT_NOW(a_bad_counts_once, out_take && out_status_bad,
                   out_bad_status_total == bumped_total)
  `JAOA_ASSERT_NOW(a_good_holds_count, out_take && !out_status_bad,
                   out_bad_status_total == last_total_r)
  `JAOA_ASSERT_NOW(a_stall_only_when_full, !in_ready, out_valid)

endmodule

bind joystick_axis_offset_average_top jaoa_port_props u_jaoa_port_props (.*);
